### sv/bpc_pkg.sv
package bpc_pkg;

  localparam int unsigned STEP_W = 4;

  localparam logic signed [18:0] T_REF_C  = 19'sd2000;
  localparam logic signed [18:0] T_COLD_C = -19'sd1500;
  localparam logic signed [63:0] P_LOW_C  = 64'sd30000;
  localparam logic signed [63:0] P_HIGH_C = 64'sd120000;

  // coefficient register indexes
  localparam logic [2:0] REG_C1 = 3'd0;
  localparam logic [2:0] REG_C2 = 3'd1;
  localparam logic [2:0] REG_C3 = 3'd2;
  localparam logic [2:0] REG_C4 = 3'd3;
  localparam logic [2:0] REG_C5 = 3'd4;
  localparam logic [2:0] REG_C6 = 3'd5;

  // jump targets in the step program
  localparam logic [STEP_W-1:0] STEP_TSUB  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_FINAL = 4'd11;

  typedef struct packed {
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
    logic [15:0] c5;
    logic [15:0] c6;
  } coef_t;

  typedef enum logic [2:0] {
    MA_DT, MA_D1, MA_DEV5, MA_COLD7, MA_COLD11
  } ma_e;

  typedef enum logic [2:0] {
    MB_C6, MB_C4, MB_C3, MB_DT, MB_DEV, MB_COLD, MB_SLO, MB_SHI
  } mb_e;

  typedef enum logic [3:0] {
    ALU_NOP, ALU_DT, ALU_TEMP, ALU_OFF_INIT, ALU_SENS_INIT, ALU_T2,
    ALU_OFF_SUB, ALU_SENS_SUB, ALU_TSUB, ALU_ACC_HI, ALU_ACC_ADD,
    ALU_ACC_OFF, ALU_DONE
  } alu_e;

  typedef enum logic [1:0] {
    JC_NONE, JC_WARM, JC_NOT_COLD
  } jc_e;

  typedef struct packed {
    logic              mul_en;
    ma_e               ma;
    mb_e               mb;
    alu_e              alu;
    logic [1:0]        sh;
    jc_e               jc;
    logic [STEP_W-1:0] jt;
  } ctrl_t;

  typedef struct packed {
    logic warm;      // first-order temperature at or above 20.00 degC
    logic not_cold;  // first-order temperature at or above -15.00 degC
  } status_t;

  // Step program. The ALU field consumes the most recently issued product.
  function automatic ctrl_t bpc_ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w.mul_en = 1'b0;
    w.ma     = MA_DT;
    w.mb     = MB_DT;
    w.alu    = ALU_NOP;
    w.sh     = 2'd0;
    w.jc     = JC_NONE;
    w.jt     = '0;
    case (step)
      4'd0: begin
        w.alu = ALU_DT;
      end
      4'd1: begin
        w.mul_en = 1'b1; w.ma = MA_DT; w.mb = MB_C6;
      end
      4'd2: begin
        w.mul_en = 1'b1; w.ma = MA_DT; w.mb = MB_C4; w.alu = ALU_TEMP;
      end
      4'd3: begin
        w.mul_en = 1'b1; w.ma = MA_DT; w.mb = MB_C3; w.alu = ALU_OFF_INIT;
      end
      4'd4: begin
        w.mul_en = 1'b1; w.ma = MA_DT; w.mb = MB_DT; w.alu = ALU_SENS_INIT;
        w.jc = JC_WARM; w.jt = STEP_FINAL;
      end
      4'd5: begin
        w.mul_en = 1'b1; w.ma = MA_DEV5; w.mb = MB_DEV; w.alu = ALU_T2;
      end
      4'd6: begin
        w.alu = ALU_OFF_SUB; w.sh = 2'd1;
      end
      4'd7: begin
        w.mul_en = 1'b1; w.ma = MA_COLD7; w.mb = MB_COLD;
        w.alu = ALU_SENS_SUB; w.sh = 2'd2;
        w.jc = JC_NOT_COLD; w.jt = STEP_TSUB;
      end
      4'd8: begin
        w.mul_en = 1'b1; w.ma = MA_COLD11; w.mb = MB_COLD;
        w.alu = ALU_OFF_SUB; w.sh = 2'd0;
      end
      4'd9: begin
        w.alu = ALU_SENS_SUB; w.sh = 2'd1;
      end
      4'd10: begin
        w.alu = ALU_TSUB;
      end
      4'd11: begin
        w.mul_en = 1'b1; w.ma = MA_D1; w.mb = MB_SHI;
      end
      4'd12: begin
        w.mul_en = 1'b1; w.ma = MA_D1; w.mb = MB_SLO; w.alu = ALU_ACC_HI;
      end
      4'd13: begin
        w.alu = ALU_ACC_ADD;
      end
      4'd14: begin
        w.alu = ALU_ACC_OFF;
      end
      4'd15: begin
        w.alu = ALU_DONE;
      end
      default: begin
        w.alu = ALU_NOP;
      end
    endcase
    return w;
  endfunction

endpackage

### sv/bpc_sequencer.sv
module bpc_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  bpc_pkg::status_t status_i,
  output bpc_pkg::ctrl_t   ctrl_o,
  output logic             accept_o,
  output logic             fire_o
);
  import bpc_pkg::*;

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  ctrl_t             ctrl;
  logic              is_done, hold, taken;

  assign ctrl     = bpc_ucode(step_q);
  assign is_done  = ctrl.alu == ALU_DONE;
  // previous result not yet taken: the final step waits
  assign hold     = out_valid_q && out_stall_i;
  assign accept_o = in_valid_i && !busy_q;
  assign fire_o   = busy_q && !(is_done && hold);

  assign taken = ((ctrl.jc == JC_WARM) && status_i.warm) ||
                 ((ctrl.jc == JC_NOT_COLD) && status_i.not_cold);

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (accept_o) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (fire_o) begin
      if (is_done) begin
        busy_d      = 1'b0;
        out_valid_d = 1'b1;
      end else if (taken) begin
        step_d = ctrl.jt;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign ctrl_o      = ctrl;

endmodule

### sv/bpc_datapath.sv
module bpc_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [23:0]      raw_pressure_i,
  input  logic [23:0]      raw_temperature_i,
  input  bpc_pkg::coef_t   coef_i,
  input  bpc_pkg::ctrl_t   ctrl_i,
  input  logic             fire_i,
  output bpc_pkg::status_t status_o,
  output logic [16:0]      pressure_pa_o,
  output logic signed [18:0] temp_centi_o,
  output logic             accepted_o,
  output logic [15:0]      implausible_count_o
);
  import bpc_pkg::*;

  // item working registers
  logic [23:0]        d1_q, d2_q;
  logic signed [24:0] dt_q, dt_d;
  logic signed [18:0] temp_q, temp_d;
  logic [16:0]        t2_q, t2_d;
  logic signed [40:0] off_q, off_d;
  logic signed [40:0] sens_q, sens_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [49:0] prod_q, prod_d;

  // held results
  logic [16:0]        held_p_q, held_p_d;
  logic signed [18:0] held_t_q, held_t_d;
  logic               ok_q, ok_d;
  logic [15:0]        cnt_q, cnt_d;

  logic signed [19:0] dev, cold;
  logic signed [22:0] dev5;
  logic signed [23:0] cold7, cold11;
  logic signed [24:0] op_a, op_b;
  logic signed [49:0] p23, p7, p8, psh;
  logic signed [63:0] a21, pv;
  logic               ok;

  assign dev    = {temp_q[18], temp_q} - {T_REF_C[18], T_REF_C};
  assign cold   = {temp_q[18], temp_q} - {T_COLD_C[18], T_COLD_C};
  assign dev5   = {{3{dev[19]}}, dev} + {dev[19], dev, 2'b00};
  assign cold7  = {cold[19], cold, 3'b000} - {{4{cold[19]}}, cold};
  assign cold11 = {cold[19], cold, 3'b000} + {{3{cold[19]}}, cold, 1'b0}
                + {{4{cold[19]}}, cold};

  always_comb begin
    case (ctrl_i.ma)
      MA_DT:     op_a = dt_q;
      MA_D1:     op_a = {1'b0, d1_q};
      MA_DEV5:   op_a = {{2{dev5[22]}}, dev5};
      MA_COLD7:  op_a = {cold7[23], cold7};
      MA_COLD11: op_a = {cold11[23], cold11};
      default:   op_a = dt_q;
    endcase
  end

  always_comb begin
    case (ctrl_i.mb)
      MB_C6:   op_b = {9'b0, coef_i.c6};
      MB_C4:   op_b = {9'b0, coef_i.c4};
      MB_C3:   op_b = {9'b0, coef_i.c3};
      MB_DT:   op_b = dt_q;
      MB_DEV:  op_b = {{5{dev[19]}}, dev};
      MB_COLD: op_b = {{5{cold[19]}}, cold};
      MB_SLO:  op_b = {1'b0, sens_q[23:0]};
      MB_SHI:  op_b = {{8{sens_q[40]}}, sens_q[40:24]};
      default: op_b = dt_q;
    endcase
  end

  assign prod_d = op_a * op_b;

  assign p23 = prod_q >>> 23;
  assign p7  = prod_q >>> 7;
  assign p8  = prod_q >>> 8;
  assign psh = prod_q >>> ctrl_i.sh;
  assign a21 = acc_q >>> 21;
  assign pv  = acc_q >>> 15;
  assign ok  = (pv >= P_LOW_C) && (pv <= P_HIGH_C);

  always_comb begin
    dt_d     = dt_q;
    temp_d   = temp_q;
    t2_d     = t2_q;
    off_d    = off_q;
    sens_d   = sens_q;
    acc_d    = acc_q;
    held_p_d = held_p_q;
    held_t_d = held_t_q;
    ok_d     = ok_q;
    cnt_d    = cnt_q;
    case (ctrl_i.alu)
      ALU_NOP: ;
      ALU_DT:        dt_d   = $signed({1'b0, d2_q}) - $signed({1'b0, coef_i.c5, 8'b0});
      ALU_TEMP:      temp_d = p23[18:0] + T_REF_C;
      ALU_OFF_INIT:  off_d  = $signed({9'b0, coef_i.c2, 16'b0}) + p7[40:0];
      ALU_SENS_INIT: sens_d = $signed({10'b0, coef_i.c1, 15'b0}) + p8[40:0];
      ALU_T2:        t2_d   = prod_q[47:31];
      ALU_OFF_SUB:   off_d  = off_q - psh[40:0];
      ALU_SENS_SUB:  sens_d = sens_q - psh[40:0];
      ALU_TSUB:      temp_d = temp_q - $signed({2'b0, t2_q});
      ALU_ACC_HI:    acc_d  = {prod_q[39:0], 24'b0};
      ALU_ACC_ADD:   acc_d  = acc_q + {{14{prod_q[49]}}, prod_q};
      ALU_ACC_OFF:   acc_d  = a21 - {{23{off_q[40]}}, off_q};
      ALU_DONE: begin
        ok_d = ok;
        if (ok) begin
          held_p_d = pv[16:0];
          held_t_d = temp_q;
        end else if (cnt_q != 16'hFFFF) begin
          cnt_d = cnt_q + 16'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      d1_q <= raw_pressure_i;
      d2_q <= raw_temperature_i;
    end
    if (fire_i) begin
      dt_q   <= dt_d;
      temp_q <= temp_d;
      t2_q   <= t2_d;
      off_q  <= off_d;
      sens_q <= sens_d;
      acc_q  <= acc_d;
      if (ctrl_i.mul_en) begin
        prod_q <= prod_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_p_q <= '0;
      held_t_q <= '0;
      ok_q     <= 1'b0;
      cnt_q    <= '0;
    end else if (fire_i) begin
      held_p_q <= held_p_d;
      held_t_q <= held_t_d;
      ok_q     <= ok_d;
      cnt_q    <= cnt_d;
    end
  end

  assign status_o.warm     = temp_q >= T_REF_C;
  assign status_o.not_cold = temp_q >= T_COLD_C;

  assign pressure_pa_o       = held_p_q;
  assign temp_centi_o        = held_t_q;
  assign accepted_o          = ok_q;
  assign implausible_count_o = cnt_q;

endmodule

### sv/baro_pressure_compensation_unit.sv
// Channel   Handshake                 Payload
// input     in_valid_i / in_stall_o   raw_pressure_i, raw_temperature_i
// output    out_valid_o / out_stall_i pressure_pa_o, temp_centi_o, accepted_o,
//                                     implausible_count_o
// config    cfg_we_i                  cfg_idx_i, cfg_data_i
//
// An item runs 10, 14 or 16 program steps after the accept cycle: 10 when the
// first-order temperature is at or above 20.00 degC, 14 down to -15.00 degC,
// 16 below. One shared 25x25 multiplier and the step program set this.
// in_stall_o is high while an item is in work; the result registers double as
// the held pressure, temperature and reject count.
// Reset clears coefficients, held values and the reject count.
// A result not yet taken makes the final step of the next item wait.
module baro_pressure_compensation_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [23:0]        raw_pressure_i,
  input  logic [23:0]        raw_temperature_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [16:0]        pressure_pa_o,
  output logic signed [18:0] temp_centi_o,
  output logic               accepted_o,
  output logic [15:0]        implausible_count_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);
  import bpc_pkg::*;

  coef_t   coef_q;
  ctrl_t   ctrl;
  status_t status;
  logic    accept, fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_C1:  coef_q.c1 <= cfg_data_i;
        REG_C2:  coef_q.c2 <= cfg_data_i;
        REG_C3:  coef_q.c3 <= cfg_data_i;
        REG_C4:  coef_q.c4 <= cfg_data_i;
        REG_C5:  coef_q.c5 <= cfg_data_i;
        REG_C6:  coef_q.c6 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bpc_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .ctrl_o      (ctrl),
    .accept_o    (accept),
    .fire_o      (fire)
  );

  bpc_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .accept_i            (accept),
    .raw_pressure_i      (raw_pressure_i),
    .raw_temperature_i   (raw_temperature_i),
    .coef_i              (coef_q),
    .ctrl_i              (ctrl),
    .fire_i              (fire),
    .status_o            (status),
    .pressure_pa_o       (pressure_pa_o),
    .temp_centi_o        (temp_centi_o),
    .accepted_o          (accepted_o),
    .implausible_count_o (implausible_count_o)
  );

endmodule

### sv/bpc_checker.sv
module bpc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [16:0]        pressure_pa_o,
  input logic signed [18:0] temp_centi_o,
  input logic               accepted_o,
  input logic [15:0]        implausible_count_o
);

  // an accepted request keeps the input side busy in the next cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after request");

  // saturating reject count never goes down
  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> implausible_count_o >= $past(implausible_count_o))
    else $error("reject count decreased");

  // held pressure is zero or within the plausible window
  a_p_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pressure_pa_o == 17'd0 || (pressure_pa_o >= 17'd30000 && pressure_pa_o <= 17'd120000))
    else $error("held pressure outside window");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pressure_pa_o) &&
      $stable(temp_centi_o) && $stable(accepted_o) && $stable(implausible_count_o))
    else $error("stalled result changed");

endmodule

bind baro_pressure_compensation_unit bpc_checker u_bpc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_stall_o          (in_stall_o),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .pressure_pa_o       (pressure_pa_o),
  .temp_centi_o        (temp_centi_o),
  .accepted_o          (accepted_o),
  .implausible_count_o (implausible_count_o)
);
